// ===== sv/lpl_pkg.sv =====
// Shared constants and controller/datapath interface types for the
// longest palindrome length unit. No dependencies.
`default_nettype none

package lpl_pkg;

  localparam int MAX_LEN = 1024;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int C2_W    = IDX_W + 1;
  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 11;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;

  typedef struct packed {
    logic load;
    logic begin_pass;
    logic pass_even;
    logic init_k;
    logic step_k;
    logic store;
    logic emit;
  } lpl_cmd_t;

  typedef struct packed {
    logic empty;
    logic probe_ok;
    logic chars_eq;
    logic last_pos;
    logic out_free;
  } lpl_stat_t;

endpackage

`default_nettype wire

// ===== sv/lpl_ctrl.sv =====
// Sequencing state machine for the longest palindrome length unit.
// Depends on lpl_pkg for the command and status structs.
`default_nettype none

module lpl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output logic                   in_ready,
  output lpl_pkg::lpl_cmd_t      cmd,
  input  wire lpl_pkg::lpl_stat_t stat
);
  import lpl_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD, S_START, S_POS, S_INIT, S_PROBE, S_CMP, S_STORE, S_DONE
  } state_t;

  state_t state;
  logic   even_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      even_pass <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_valid && in_last) begin
            state     <= S_START;
            even_pass <= 1'b0;
          end
        end
        S_START: state <= stat.empty ? S_DONE : S_POS;
        S_POS:   state <= S_INIT;
        S_INIT:  state <= S_PROBE;
        S_PROBE: state <= stat.probe_ok ? S_CMP : S_STORE;
        S_CMP:   state <= stat.chars_eq ? S_PROBE : S_STORE;
        S_STORE: begin
          if (!stat.last_pos) begin
            state <= S_POS;
          end else if (even_pass) begin
            state <= S_DONE;
          end else begin
            state     <= S_START;
            even_pass <= 1'b1;
          end
        end
        S_DONE: begin
          if (stat.out_free) begin
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    in_ready       = (state == S_LOAD);
    cmd.load       = in_ready && in_valid;
    cmd.begin_pass = (state == S_START);
    cmd.pass_even  = even_pass;
    cmd.init_k     = (state == S_INIT);
    cmd.step_k     = (state == S_CMP) && stat.chars_eq;
    cmd.store      = (state == S_STORE);
    cmd.emit       = (state == S_DONE) && stat.out_free;
  end

endmodule

`default_nettype wire

// ===== sv/lpl_datapath.sv =====
// Character buffer, radius memory, Manacher pointers and result register.
// Depends on lpl_pkg; driven by commands from lpl_ctrl.
`default_nettype none

module lpl_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [lpl_pkg::CHAR_W-1:0]  char_in,
  input  wire lpl_pkg::lpl_cmd_t           cmd,
  output lpl_pkg::lpl_stat_t               stat,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [lpl_pkg::LEN_W-1:0]        out_len,
  output logic                             out_ovf
);
  import lpl_pkg::*;

  logic [CHAR_W-1:0] buf_mem [MAX_LEN];
  logic [CNT_W-1:0]  rad_mem [MAX_LEN];

  logic [CNT_W-1:0]  count;
  logic              ovf;
  logic [IDX_W-1:0]  i;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  hi_p1;
  logic [C2_W-1:0]   c2;
  logic              even;
  logic [CNT_W-1:0]  best;

  logic [CHAR_W-1:0] buf_a_q, buf_b_q;
  logic [CNT_W-1:0]  rad_q;

  logic [CNT_W:0]    sum_ik, diff_ik, cand;
  logic [IDX_W-1:0]  addr_a, addr_b, mir;
  logic [CNT_W-1:0]  lim, kmin, i_w, k_init;
  logic              in_span;

  always_comb begin
    i_w     = CNT_W'(i);
    sum_ik  = (CNT_W+1)'(i) + (CNT_W+1)'(k);
    diff_ik = (CNT_W+1)'(i) - (CNT_W+1)'(k) - (CNT_W+1)'(even);
    addr_a  = sum_ik[IDX_W-1:0];
    addr_b  = diff_ik[IDX_W-1:0];
    mir     = IDX_W'(c2 - C2_W'(i));
    in_span = i_w < hi_p1;
    lim     = hi_p1 - i_w;
    kmin    = (rad_q < lim) ? rad_q : lim;
    if (even) begin
      k_init = in_span ? kmin : '0;
    end else begin
      k_init = (in_span && kmin != '0) ? kmin : CNT_W'(1);
    end
    cand = {k, 1'b0} - (CNT_W+1)'(!even);

    stat.empty    = (count == '0);
    stat.probe_ok = (sum_ik < (CNT_W+1)'(count)) && (even ? (k < i_w) : (k <= i_w));
    stat.chars_eq = (buf_a_q == buf_b_q);
    stat.last_pos = ((i_w + CNT_W'(1)) == count);
    stat.out_free = !out_valid || out_ready;
  end

  // Memories: one write port, registered reads.
  always_ff @(posedge clk) begin
    if (cmd.load && char_in != SPACE_CHAR && count < CNT_W'(MAX_LEN)) begin
      buf_mem[count[IDX_W-1:0]] <= char_in;
    end
    buf_a_q <= buf_mem[addr_a];
    buf_b_q <= buf_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      rad_mem[i] <= k;
    end
    rad_q <= rad_mem[mir];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.emit) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.load && char_in != SPACE_CHAR) begin
      if (count < CNT_W'(MAX_LEN)) begin
        count <= count + CNT_W'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.begin_pass) begin
      i     <= '0;
      hi_p1 <= '0;
      c2    <= '0;
      even  <= cmd.pass_even;
    end else if (cmd.store) begin
      i <= i + IDX_W'(1);
      if (sum_ik > (CNT_W+1)'(hi_p1)) begin
        hi_p1 <= sum_ik[CNT_W-1:0];
        c2    <= {i, 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_k) begin
      k <= k_init;
    end else if (cmd.step_k) begin
      k <= k + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.begin_pass && !cmd.pass_even) begin
      best <= '0;
    end else if (cmd.store && cand > (CNT_W+1)'(best)) begin
      best <= cand[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_len <= LEN_W'(best);
      out_ovf <= ovf;
    end
  end

endmodule

`default_nettype wire

// ===== sv/longest_palindrome_length_unit.sv =====
// Longest palindromic substring length: streaming top level.
// Depends on lpl_pkg, lpl_ctrl and lpl_datapath.
//
// The unit takes a string one byte per word on the slave side, with tlast
// on the final byte, drops space bytes and stores up to MAX_LEN (1024)
// characters; further characters are dropped and the overflow flag is set.
// Loading runs at one word per cycle. After the final word the unit stops
// accepting input and runs Manacher's algorithm twice over the buffer,
// once for odd and once for even centers. Each pass opens with a start
// step. For each stored character the unit then reads the mirrored
// radius, sets the starting radius and probes; while a probe stays inside
// the string it compares a pair of characters and, on a match, grows the
// radius and probes again. On a probe that runs off the string or on a
// mismatch it stores the radius and moves on. The result word then
// appears on the master side and the unit takes the next string right
// away, even while that result is still waiting. An empty string gives a
// length of 0.
`default_nettype none

module longest_palindrome_length_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_in
  input  wire logic        s_tlast,   // last_char
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [10:0] palindrome_length, rest zero
  output logic [0:0]       m_tuser    // [0] overflowed
);
  import lpl_pkg::*;

  lpl_cmd_t           cmd;
  lpl_stat_t          stat;
  logic [LEN_W-1:0]   out_len;
  logic               out_ovf;

  // The controller owns sequencing; the datapath owns all storage.
  lpl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  lpl_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .char_in   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_len   (out_len),
    .out_ovf   (out_ovf)
  );

  assign m_tdata = 16'(out_len);
  assign m_tuser = out_ovf;

  // After the final word the unit must stop taking input until it reports.
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input accepted right after the final word");

  // A new result is raised only as the unit returns to loading.
  a_result_then_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result raised while the unit is still busy");

  // Emitting requires the result register to be free or draining.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

// ===== test/longest_palindrome_length_unit_tb.sv =====
// Self-checking testbench for longest_palindrome_length_unit: streams strings
// in, predicts each palindrome length and overflow flag, and checks every result.
// Depends on lpl_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module longest_palindrome_length_unit_tb;
  import lpl_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 300;

  // One input word: a character byte and the end-of-string marker.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_word_t;

  // One result word as the unit should deliver it.
  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             overflowed;
  } palin_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;

  longest_palindrome_length_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Words waiting to be driven, and results the unit still owes us.
  char_word_t    pending_words[$];
  palin_result_t awaited_results[$];

  // Predictor state: the characters stored so far for the current string.
  logic [CHAR_W-1:0] stored_chars[$];
  logic              buffer_overflow;

  int  fail_count;
  int  cycle_count;
  int  strings_queued;
  int  results_checked;
  int  overflow_results;
  int  longest_seen;
  bit  word_held;
  int  burst_left;
  int  gap_left;
  int  ready_mode;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Length of the longest palindromic run in the stored characters. Every
  // center is tried, both on a character (odd lengths) and between two
  // characters (even lengths), so the result does not depend on parity.
  function automatic logic [LEN_W-1:0] longest_palindrome_len(
    input logic [CHAR_W-1:0] chars[$]);
    int n;
    int best;
    int r;
    n = chars.size();
    best = 0;
    for (int c = 0; c < n; c++) begin
      r = 0;
      while (c - r - 1 >= 0 && c + r + 1 < n && chars[c-r-1] == chars[c+r+1])
        r++;
      if (2 * r + 1 > best)
        best = 2 * r + 1;
      r = 0;
      while (c - r - 1 >= 0 && c + r < n && chars[c-r-1] == chars[c+r])
        r++;
      if (2 * r > best)
        best = 2 * r;
    end
    return best[LEN_W-1:0];
  endfunction

  // Applies one accepted word to the predictor. Spaces never reach the
  // buffer; once it is full further characters only raise the overflow flag.
  // The final word of a string closes it and queues the expected result.
  function automatic void absorb_word(input logic [CHAR_W-1:0] ch, input logic last);
    palin_result_t res;
    if (ch != SPACE_CHAR) begin
      if (stored_chars.size() < MAX_LEN)
        stored_chars.push_back(ch);
      else
        buffer_overflow = 1'b1;
    end
    if (last) begin
      res.length = longest_palindrome_len(stored_chars);
      res.overflowed = buffer_overflow;
      awaited_results.push_back(res);
      stored_chars.delete();
      buffer_overflow = 1'b0;
    end
  endfunction

  task automatic push_word(input logic [CHAR_W-1:0] ch, input logic last);
    char_word_t w;
    w.ch = ch;
    w.last = last;
    pending_words.push_back(w);
    if (last)
      strings_queued++;
  endtask

  // Queues a literal string, with the end marker on its final byte.
  task automatic push_text(input string text);
    for (int i = 0; i < text.len(); i++)
      push_word(text[i], i == text.len() - 1);
  endtask

  // Mostly a three-letter alphabet so that palindromes actually occur, with
  // spaces and arbitrary bytes mixed in.
  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6)
      return 8'h61 + 8'($urandom_range(0, 2));
    else if (r < 8)
      return SPACE_CHAR;
    else
      return 8'($urandom_range(0, 255));
  endfunction

  // Queues one random string. Half of them are built as palindromes around
  // random content, some of those with one character spoiled; the rest are
  // random text or plain byte noise. A string with nothing in it still ends
  // with a marked space word.
  task automatic add_random_string();
    logic [CHAR_W-1:0] text[$];
    logic [CHAR_W-1:0] half[$];
    int len;
    int kind;
    kind = $urandom_range(0, 9);
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 20);
    if (kind < 5) begin
      for (int i = 0; i < len / 2; i++)
        half.push_back(pick_char());
      text = half;
      if (len % 2 == 1)
        text.push_back(pick_char());
      for (int i = half.size() - 1; i >= 0; i--)
        text.push_back(half[i]);
      if (kind == 4 && text.size() > 0)
        text[$urandom_range(0, text.size() - 1)] = pick_char();
    end else if (kind < 8) begin
      for (int i = 0; i < len; i++)
        text.push_back(pick_char());
    end else begin
      for (int i = 0; i < len; i++)
        text.push_back(8'($urandom_range(0, 255)));
    end
    if (text.size() == 0)
      text.push_back(SPACE_CHAR);
    for (int i = 0; i < text.size(); i++)
      push_word(text[i], i == text.size() - 1);
  endtask

  // Reset, then the whole stimulus is queued up front; the driver below
  // drains it. The end of the run waits for both queues to empty.
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    strings_queued = 0;
    results_checked = 0;
    overflow_results = 0;
    longest_seen = 0;
    word_held = 0;
    burst_left = 0;
    gap_left = 0;
    ready_mode = 0;
    buffer_overflow = 1'b0;

    // Directed strings: an empty string, a single character, even and odd
    // palindromes, a string that ends on a space with spaces inside, the
    // lowest and highest byte values, and text with no repeated characters.
    push_text(" ");
    push_text("x");
    push_text("abba");
    push_text("abcba");
    push_text("a b a ");
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h00, 1'b1);
    push_text("xyz");

    while (pending_words.size() < 800)
      add_random_string();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_words.size() > 0 || word_held || awaited_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (awaited_results.size() > 0) begin
      $error("%0d results never arrived", awaited_results.size());
      fail_count++;
    end
    $display("Sent %0d strings, checked %0d results (%0d with overflow).",
             strings_queued, results_checked, overflow_results);
    $display("Longest palindrome seen: %0d characters.", longest_seen);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Driver. Words go out in bursts of random length separated by random
  // gaps; a word stays on the bus until the unit takes it. A gap of zero is
  // common, so long back-to-back stretches occur too.
  always @(negedge clk) begin
    if (!rst && !word_held) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_words[0].ch;
        s_tlast <= pending_words[0].last;
        pending_words.pop_front();
        word_held = 1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver. The stall pattern switches at random among always ready,
  // ready about half the time, and ready about one time in eight.
  always @(negedge clk) begin
    if (cycle_count % 64 == 0)
      ready_mode = $urandom_range(0, 2);
    case (ready_mode)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_tready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  // Monitor: takes accepted input words into the predictor and compares
  // each accepted result word with the oldest expected one.
  always @(posedge clk) begin
    palin_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        absorb_word(s_tdata, s_tlast);
        word_held = 0;
      end
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result word with no string pending: length %0d overflowed %0d",
                 m_tdata[LEN_W-1:0], m_tuser[0]);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (want.overflowed)
            overflow_results++;
          if (int'(want.length) > longest_seen)
            longest_seen = int'(want.length);
          if (m_tdata[LEN_W-1:0] !== want.length) begin
            $error("palindrome_length: expected %0d, actual %0d",
                   want.length, m_tdata[LEN_W-1:0]);
            fail_count++;
          end
          if (m_tdata[15:LEN_W] !== '0) begin
            $error("tdata padding: expected 0, actual %0h", m_tdata[15:LEN_W]);
            fail_count++;
          end
          if (m_tuser[0] !== want.overflowed) begin
            $error("overflowed: expected %0d, actual %0d", want.overflowed, m_tuser[0]);
            fail_count++;
          end
        end
      end
    end
  end

endmodule
